// File: sv/ecb_pkg.sv
// ----------------------------------------------------------------------------
// ecb_pkg
// shared types and constants for the edge coverage bitmap core
// ----------------------------------------------------------------------------
package ecb_pkg;

    localparam int unsigned ADDR_BITS          = 16;
    localparam int unsigned ADDR_SPAN          = 65536;
    localparam int unsigned DEF_MAP_ENTRIES    = 65536;
    localparam int unsigned DEF_MAX_LIST_EDGES = 256;
    localparam int unsigned CNT_W              = 9;
    localparam int unsigned TOT_W              = 17;
    localparam int unsigned QUERY_STOP         = 5;
    localparam int unsigned RUN_CAP_MAX        = 511;
    localparam int unsigned Q_DEPTH            = 4;

    typedef enum logic [1:0] {
        K_UPDATE  = 2'd0,
        K_QUERY   = 2'd1,
        K_INIT    = 2'd2,
        K_RELEASE = 2'd3
    } t_kind;

    // one classified operation handed from the front to the back
    typedef struct packed {
        t_kind                kind;
        logic                 has_edge;
        logic                 last;
        logic [ADDR_BITS-1:0] idx;
    } t_op;

endpackage

// File: sv/ecb_front.sv
// ----------------------------------------------------------------------------
// ecb_front
// accepts input transactions, drops empty ones and reduces the address
// to a map index before handing them to the queue
// ----------------------------------------------------------------------------
module ecb_front import ecb_pkg::*; #(
    parameter int unsigned MAP_ENTRIES = DEF_MAP_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_kind,
    input  logic [63:0]          i_edge_addr,
    input  logic                 i_has_edge,
    input  logic                 i_last,
    output logic                 o_push,
    output t_op                  o_op,
    input  logic                 i_q_full
);

    localparam bit          IS_POW2   = (MAP_ENTRIES & (MAP_ENTRIES - 1)) == 0;
    localparam int unsigned RED_STEPS = IS_POW2 ? 1 :
        $clog2((ADDR_SPAN + MAP_ENTRIES - 1) / MAP_ENTRIES);
    localparam int unsigned LEFT_W    = $clog2(RED_STEPS + 1);
    localparam int unsigned DIV_W     = ADDR_BITS + 2;

    logic              r_hold;
    logic [LEFT_W-1:0] r_left;
    t_op               r_op;

    t_kind              w_kind;
    logic               w_list;
    logic               w_keep;
    logic               w_push;
    logic               w_take;
    logic [DIV_W-1:0]   w_div;
    logic [ADDR_BITS-1:0] w_idx_in;

    always_comb begin
        w_kind  = t_kind'(i_kind);
        w_list  = (w_kind == K_UPDATE) || (w_kind == K_QUERY);
        // a list item with neither edge nor last has no effect
        w_keep  = !w_list || i_has_edge || i_last;
        w_push  = r_hold && (r_left == '0) && !i_q_full;
        w_take  = i_valid && (!r_hold || w_push);
        w_div   = DIV_W'(MAP_ENTRIES) << (r_left - LEFT_W'(1));
        w_idx_in = IS_POW2 ? (i_edge_addr[ADDR_BITS-1:0] & ADDR_BITS'(MAP_ENTRIES - 1))
                           : i_edge_addr[ADDR_BITS-1:0];
    end

    assign o_stall = r_hold && !w_push;
    assign o_push  = w_push;
    assign o_op    = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_left <= '0;
        end else if (w_take) begin
            r_hold <= w_keep;
            r_left <= (w_list && i_has_edge && !IS_POW2) ? LEFT_W'(RED_STEPS) : '0;
        end else if (w_push) begin
            r_hold <= 1'b0;
        end else if (r_hold && r_left != '0) begin
            r_left <= r_left - LEFT_W'(1);
        end
    end

    // restoring reduction, one shifted modulus per cycle
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op.kind     <= w_kind;
            r_op.has_edge <= w_list && i_has_edge;
            r_op.last     <= i_last;
            r_op.idx      <= w_idx_in;
        end else if (r_hold && r_left != '0) begin
            if ({2'b00, r_op.idx} >= w_div) begin
                r_op.idx <= r_op.idx - w_div[ADDR_BITS-1:0];
            end
        end
    end

endmodule

// File: sv/ecb_fifo.sv
// ----------------------------------------------------------------------------
// ecb_fifo
// short operation queue between the front and the back
// ----------------------------------------------------------------------------
module ecb_fifo import ecb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_data,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_data,
    output logic o_empty
);

    localparam int unsigned PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned CNT_QW = $clog2(Q_DEPTH + 1);

    t_op               r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_QW-1:0] r_cnt;

    logic w_wr;
    logic w_rd;

    assign o_full  = r_cnt == CNT_QW'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CNT_QW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CNT_QW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: sv/ecb_back.sv
// ----------------------------------------------------------------------------
// ecb_back
// owns the hit map and the counters, executes queued operations and
// holds the result register
// ----------------------------------------------------------------------------
module ecb_back import ecb_pkg::*; #(
    parameter int unsigned MAP_ENTRIES    = DEF_MAP_ENTRIES,
    parameter int unsigned MAX_LIST_EDGES = DEF_MAX_LIST_EDGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_op              i_op,
    input  logic             i_q_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CNT_W-1:0] o_new_count,
    output logic [TOT_W-1:0] o_covered_total,
    output logic             o_map_ready
);

    localparam int unsigned IDX_W   = $clog2(MAP_ENTRIES);
    localparam int unsigned RUN_CAP = (MAX_LIST_EDGES < RUN_CAP_MAX) ? MAX_LIST_EDGES
                                                                     : RUN_CAP_MAX;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic             r_enabled;
    logic [CNT_W-1:0] r_run;
    logic [TOT_W-1:0] r_covered;
    logic [IDX_W-1:0] r_clr;
    logic [IDX_W-1:0] r_idx;
    logic             r_query;
    logic             r_last;
    logic             r_ovalid;
    logic [CNT_W-1:0] r_o_new;
    logic [TOT_W-1:0] r_o_cov;
    logic             r_o_ready;

    logic             r_map [MAP_ENTRIES];
    logic             r_rdata;

    logic             w_pop;
    logic             w_out_free;
    logic             w_emit;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic             w_wdata;
    logic [IDX_W-1:0] w_raddr;

    always_comb begin
        w_pop      = (r_state == S_IDLE) && !i_q_empty;
        w_out_free = !r_ovalid || !i_stall;
        w_emit     = (r_state == S_EMIT) && w_out_free;
        w_raddr    = i_op.idx[IDX_W-1:0];
        w_we       = 1'b0;
        w_waddr    = r_idx;
        w_wdata    = 1'b1;
        if (r_state == S_READ && !r_query && !r_rdata) begin
            w_we = 1'b1;
        end else if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = 1'b0;
        end
    end

    // map with one read and one write port, read data registered; map bits
    // are only visible after an init sweep, so reset leaves them alone
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[w_waddr] <= w_wdata;
        end
        r_rdata <= r_map[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_enabled <= 1'b0;
            r_run     <= '0;
            r_covered <= '0;
            r_clr     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        unique case (i_op.kind)
                            K_INIT: begin
                                r_run     <= '0;
                                r_covered <= '0;
                                r_enabled <= 1'b1;
                                r_clr     <= '0;
                                r_state   <= S_CLEAR;
                            end
                            K_RELEASE: begin
                                r_enabled <= 1'b0;
                                r_run     <= '0;
                            end
                            K_UPDATE, K_QUERY: begin
                                r_idx   <= i_op.idx[IDX_W-1:0];
                                r_query <= i_op.kind == K_QUERY;
                                r_last  <= i_op.last;
                                if (i_op.has_edge && r_enabled) begin
                                    r_state <= S_READ;
                                end else if (i_op.last) begin
                                    r_state <= S_EMIT;
                                end
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (!r_rdata) begin
                        if (!r_query) begin
                            if (r_run < CNT_W'(RUN_CAP)) begin
                                r_run <= r_run + CNT_W'(1);
                            end
                            if (r_covered < TOT_W'(MAP_ENTRIES)) begin
                                r_covered <= r_covered + TOT_W'(1);
                            end
                        end else if (r_run < CNT_W'(QUERY_STOP)
                                     && r_run < CNT_W'(RUN_CAP)) begin
                            r_run <= r_run + CNT_W'(1);
                        end
                    end
                    r_state <= r_last ? S_EMIT : S_IDLE;
                end
                S_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == IDX_W'(MAP_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        // disabled map: update reports 0, query reports 1
                        r_o_new   <= r_enabled ? r_run : CNT_W'(r_query);
                        r_o_cov   <= r_enabled ? r_covered : '0;
                        r_o_ready <= r_enabled;
                        r_run     <= '0;
                        r_state   <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_pop           = w_pop;
    assign o_valid         = r_ovalid;
    assign o_new_count     = r_o_new;
    assign o_covered_total = r_o_cov;
    assign o_map_ready     = r_o_ready;

    a_cov_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_covered <= TOT_W'(MAP_ENTRIES))
        else $error("covered count above map size");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run <= CNT_W'(RUN_CAP))
        else $error("run count above cap");

    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_EMIT)
        else $error("result raised outside emit");

    a_idle_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_EMIT) |-> !w_we)
        else $error("map written while not updating or clearing");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_o_ready) |-> (r_o_cov == '0))
        else $error("disabled map reports nonzero total");

endmodule

// File: sv/edge_coverage_bitmap_core.sv
// ----------------------------------------------------------------------------
// edge_coverage_bitmap_core
// one-bit coverage map fed with edge lists, with a front, an operation
// queue and a back that owns the map
// ----------------------------------------------------------------------------
// path from closing item to result: front register, queue, map read and write state
//   (only with an edge), emit state, result register; per edge the map is read, then
//   written, and the back pops no new operation before the last one is done
// init clears every map bit while front and queue hold up to 5 transactions
// non power of two MAP_ENTRIES adds index reduction in the front per edge, stalling input
// reset: control and counters cleared, map disabled; map bits left, init clears them
module edge_coverage_bitmap_core import ecb_pkg::*; #(
    parameter int unsigned MAP_ENTRIES    = DEF_MAP_ENTRIES,
    parameter int unsigned MAX_LIST_EDGES = DEF_MAX_LIST_EDGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_kind,
    input  logic [63:0]      i_edge_addr,
    input  logic             i_has_edge,
    input  logic             i_last,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CNT_W-1:0] o_new_count,
    output logic [TOT_W-1:0] o_covered_total,
    output logic             o_map_ready
);

    logic w_push;
    t_op  w_push_op;
    logic w_q_full;
    logic w_pop;
    t_op  w_head_op;
    logic w_q_empty;

    ecb_front #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_edge_addr (i_edge_addr),
        .i_has_edge  (i_has_edge),
        .i_last      (i_last),
        .o_push      (w_push),
        .o_op        (w_push_op),
        .i_q_full    (w_q_full)
    );

    ecb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_op),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_head_op),
        .o_empty (w_q_empty)
    );

    ecb_back #(
        .MAP_ENTRIES    (MAP_ENTRIES),
        .MAX_LIST_EDGES (MAX_LIST_EDGES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (w_head_op),
        .i_q_empty       (w_q_empty),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_new_count     (o_new_count),
        .o_covered_total (o_covered_total),
        .o_map_ready     (o_map_ready)
    );

endmodule
